[sv/c3c_pkg.sv]
package c3c_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int COEF_FRAC_BITS = 8;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WCFG_W = 11;
    localparam int HCFG_W = 13;
    localparam int TAP_W  = 12;
    localparam int TLO_W  = 60;
    localparam int THI_W  = 48;
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;

    localparam int DATA_W  = 64;
    localparam int PADDR_W = 5;

    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_TAPS_LO = 2'd2;
    localparam logic [1:0] REG_TAPS_HI = 2'd3;

    localparam int K_MM = 0;
    localparam int K_ME = 1;
    localparam int K_BM = 2;
    localparam int K_BE = 3;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [2:0] t_col;
    typedef t_pix [8:0] t_win;
    typedef logic [8:0][TAP_W-1:0] t_taps;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             done;
        logic             last;
    } t_tag;

endpackage

[sv/conv3x3_rgb_clamp_edge.sv]
// 3x3 RGB convolution with clamp-to-edge borders over a raster pixel stream. One pixel is
// taken per clock while o_ready is high; filtered pixels come out one row and one column
// behind, each tagged with its column, row, a frame-done flag on the bottom-right pixel and a
// flag on the last result a pixel causes. The first row gives no results, column 0 of later
// rows none, interior pixels one, the right column and the bottom row two, the bottom-right
// pixel four. All results of a pixel share one filter pipeline that finishes one result per
// clock unless the output stalls, so a pixel with several results holds the input until the
// last of them is issued. Two 1024-entry line stores, read once and written once per pixel,
// feed a chain of three window column cells. Kernel taps are 12-bit signed with 8 fraction
// bits; sums are floored and clamped to 0..255. Configure only while idle.
module conv3x3_rgb_clamp_edge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [c3c_pkg::PADDR_W-1:0] paddr,
    input  logic [c3c_pkg::DATA_W-1:0]  pwdata,
    output logic [c3c_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_red_in,
    input  logic [7:0]                  i_green_in,
    input  logic [7:0]                  i_blue_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_red_out,
    output logic [7:0]                  o_green_out,
    output logic [7:0]                  o_blue_out,
    output logic [9:0]                  o_out_col,
    output logic [11:0]                 o_out_row,
    output logic                        o_frame_done,
    output logic                        o_run_last
);
    import c3c_pkg::*;

    function automatic logic [1:0] wrap(input logic [1:0] k, input logic edge_map);
        if (!edge_map) begin
            return k;
        end
        return (k == 2'd0) ? 2'd1 : 2'd2;
    endfunction

    logic [WCFG_W-1:0] r_frame_width;
    logic [HCFG_W-1:0] r_frame_height;
    logic [TLO_W-1:0]  r_taps_lo;
    logic [THI_W-1:0]  r_taps_hi;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[PADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WCFG_W'(640);
            r_frame_height <= HCFG_W'(480);
            r_taps_lo      <= TLO_W'(256);
            r_taps_hi      <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WIDTH:   r_frame_width  <= pwdata[WCFG_W-1:0];
                REG_HEIGHT:  r_frame_height <= pwdata[HCFG_W-1:0];
                REG_TAPS_LO: r_taps_lo      <= pwdata[TLO_W-1:0];
                REG_TAPS_HI: r_taps_hi      <= pwdata[THI_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:   prdata = {{(DATA_W-WCFG_W){1'b0}}, r_frame_width};
            REG_HEIGHT:  prdata = {{(DATA_W-HCFG_W){1'b0}}, r_frame_height};
            REG_TAPS_LO: prdata = {{(DATA_W-TLO_W){1'b0}}, r_taps_lo};
            REG_TAPS_HI: prdata = {{(DATA_W-THI_W){1'b0}}, r_taps_hi};
            default:     prdata = '0;
        endcase
    end

    t_taps taps;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            taps[k] = r_taps_lo[TAP_W*k +: TAP_W];
        end
        for (int k = 5; k < 9; k++) begin
            taps[k] = r_taps_hi[TAP_W*(k-5) +: TAP_W];
        end
    end

    logic [WCFG_W-1:0] w_sat;
    logic [HCFG_W-1:0] h_sat;
    logic [WCFG_W-1:0] w_m1_full;
    logic [HCFG_W-1:0] h_m1_full;
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;

    always_comb begin
        if (r_frame_width < WCFG_W'(2)) begin
            w_sat = WCFG_W'(2);
        end else if (r_frame_width > WCFG_W'(MAX_WIDTH)) begin
            w_sat = WCFG_W'(MAX_WIDTH);
        end else begin
            w_sat = r_frame_width;
        end
        if (r_frame_height < HCFG_W'(2)) begin
            h_sat = HCFG_W'(2);
        end else if (r_frame_height > HCFG_W'(MAX_HEIGHT)) begin
            h_sat = HCFG_W'(MAX_HEIGHT);
        end else begin
            h_sat = r_frame_height;
        end
        w_m1_full = w_sat - WCFG_W'(1);
        h_m1_full = h_sat - HCFG_W'(1);
        w_m1      = w_m1_full[COL_W-1:0];
        h_m1      = h_m1_full[ROW_W-1:0];
    end

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             accept;
    logic             last_col;
    logic             last_row;
    logic [3:0]       in_mask;

    assign accept   = i_valid & o_ready;
    assign last_col = r_col >= w_m1;
    assign last_row = r_row >= h_m1;

    always_comb begin
        in_mask = '0;
        if (r_row != '0) begin
            in_mask[K_MM] = r_col != '0;
            in_mask[K_ME] = last_col;
            in_mask[K_BM] = last_row && (r_col != '0);
            in_mask[K_BE] = last_row && last_col;
        end
    end

    logic             r_s1_v;
    t_pix             r_s1_pix;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic [3:0]       r_s1_mask;
    logic             r_s1_near_top;
    logic             r_s1_load;
    t_pix             r_rd_a;
    t_pix             r_rd_b;
    logic             s1_adv;

    logic [3:0]       r_c_mask;
    logic [COL_W-1:0] r_c_col;
    logic [ROW_W-1:0] r_c_row;
    logic [3:0]       sel;
    logic [3:0]       rest;
    logic             c_busy;
    logic             mac_ready;
    logic             issue;
    logic             c_take;

    assign c_busy  = |r_c_mask;
    assign sel     = r_c_mask & (~r_c_mask + 4'd1);
    assign rest    = r_c_mask & ~sel;
    assign issue   = c_busy && mac_ready;
    assign c_take  = !c_busy || (issue && (rest == '0));
    assign s1_adv  = r_s1_v && c_take;
    assign o_ready = !r_s1_v || c_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_v   <= 1'b0;
            r_c_mask <= '0;
        end else begin
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (o_ready) begin
                r_s1_v <= i_valid;
            end
            if (s1_adv) begin
                r_c_mask <= r_s1_mask;
            end else if (issue) begin
                r_c_mask <= rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= {i_red_in, i_green_in, i_blue_in};
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_mask     <= in_mask;
            r_s1_near_top <= r_row <= ROW_W'(1);
            r_s1_load     <= r_col == '0;
        end
        if (s1_adv) begin
            r_c_col <= r_s1_col;
            r_c_row <= r_s1_row;
        end
    end

    t_pix mem_a [MAX_WIDTH];
    t_pix mem_b [MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_a <= mem_a[r_col];
        end
        if (s1_adv) begin
            mem_a[r_s1_col] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_b <= mem_b[r_col];
        end
        if (s1_adv) begin
            mem_b[r_s1_col] <= r_rd_a;
        end
    end

    t_col new_col;
    t_col cell_q   [3];
    t_col cell_nbr [3];
    logic cell_load [3];

    assign new_col[0] = r_s1_near_top ? r_rd_a : r_rd_b;
    assign new_col[1] = r_rd_a;
    assign new_col[2] = r_s1_pix;

    for (genvar k = 0; k < 3; k++) begin : g_cell
        if (k == 2) begin : g_head
            assign cell_nbr[k]  = new_col;
            assign cell_load[k] = 1'b0;
        end else begin : g_body
            assign cell_nbr[k]  = cell_q[k+1];
            assign cell_load[k] = r_s1_load;
        end
        c3c_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (s1_adv),
            .i_load (cell_load[k]),
            .i_new  (new_col),
            .i_nbr  (cell_nbr[k]),
            .o_col  (cell_q[k])
        );
    end

    t_win win;
    t_tag req_tag;
    logic bot_map;
    logic end_map;

    assign bot_map = sel[K_BM] | sel[K_BE];
    assign end_map = sel[K_ME] | sel[K_BE];

    always_comb begin
        for (int ky = 0; ky < 3; ky++) begin
            for (int kx = 0; kx < 3; kx++) begin
                win[3*ky+kx] = cell_q[wrap(2'(kx), end_map)][wrap(2'(ky), bot_map)];
            end
        end
        req_tag.col  = (sel[K_MM] | sel[K_BM]) ? r_c_col - COL_W'(1) : r_c_col;
        req_tag.row  = (sel[K_MM] | sel[K_ME]) ? r_c_row - ROW_W'(1) : r_c_row;
        req_tag.done = sel[K_BE];
        req_tag.last = rest == '0;
    end

    t_tag out_tag;

    c3c_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_busy),
        .o_ready (mac_ready),
        .i_win   (win),
        .i_tag   (req_tag),
        .i_taps  (taps),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out),
        .o_tag   (out_tag)
    );

    assign o_out_col    = out_tag.col;
    assign o_out_row    = out_tag.row;
    assign o_frame_done = out_tag.done;
    assign o_run_last   = out_tag.last;

endmodule

[sv/c3c_cell.sv]
module c3c_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_load,
    input  c3c_pkg::t_col i_new,
    input  c3c_pkg::t_col i_nbr,
    output c3c_pkg::t_col o_col
);
    import c3c_pkg::*;

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col <= i_load ? i_new : i_nbr;
        end
    end

    assign o_col = r_col;

endmodule

[sv/c3c_mac.sv]
module c3c_mac (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  c3c_pkg::t_win            i_win,
    input  c3c_pkg::t_tag            i_tag,
    input  c3c_pkg::t_taps           i_taps,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [c3c_pkg::CH_W-1:0] o_red,
    output logic [c3c_pkg::CH_W-1:0] o_green,
    output logic [c3c_pkg::CH_W-1:0] o_blue,
    output c3c_pkg::t_tag            o_tag
);
    import c3c_pkg::*;

    localparam int PROD_W = CH_W + TAP_W + 1;
    localparam int RSUM_W = PROD_W + 1;
    localparam int TOT_W  = PROD_W + 3;

    function automatic logic signed [PROD_W-1:0] mul(input logic [CH_W-1:0] p,
                                                       input logic [TAP_W-1:0] t);
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        a = {{(PROD_W-CH_W){1'b0}}, p};
        b = {{(PROD_W-TAP_W){t[TAP_W-1]}}, t};
        return a * b;
    endfunction

    function automatic logic [CH_W-1:0] shade(input logic signed [TOT_W-1:0] s);
        logic signed [TOT_W-1:0] q;
        q = s >>> COEF_FRAC_BITS;
        if (q < 0) begin
            return '0;
        end else if (q > TOT_W'(signed'((1 << CH_W) - 1))) begin
            return '1;
        end
        return q[CH_W-1:0];
    endfunction

    logic                     r_v1, r_v2, r_v3;
    logic                     rdy1, rdy2, rdy3;
    logic signed [PROD_W-1:0] r_p1 [3][9];
    logic signed [RSUM_W-1:0] r_s2 [3][3];
    logic [CH_W-1:0]          r_o3 [3];
    t_tag                     r_tag1, r_tag2, r_tag3;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_tag1 <= i_tag;
            for (int ch = 0; ch < 3; ch++) begin
                for (int k = 0; k < 9; k++) begin
                    r_p1[ch][k] <= mul(i_win[k][(2-ch)*CH_W +: CH_W], i_taps[k]);
                end
            end
        end
        if (rdy2 && r_v1) begin
            r_tag2 <= r_tag1;
            for (int ch = 0; ch < 3; ch++) begin
                for (int ky = 0; ky < 3; ky++) begin
                    r_s2[ch][ky] <= {r_p1[ch][3*ky][PROD_W-1], r_p1[ch][3*ky]}
                                  + {r_p1[ch][3*ky+1][PROD_W-1], r_p1[ch][3*ky+1]}
                                  + {r_p1[ch][3*ky+2][PROD_W-1], r_p1[ch][3*ky+2]};
                end
            end
        end
        if (rdy3 && r_v2) begin
            r_tag3 <= r_tag2;
            for (int ch = 0; ch < 3; ch++) begin
                r_o3[ch] <= shade({{2{r_s2[ch][0][RSUM_W-1]}}, r_s2[ch][0]}
                                + {{2{r_s2[ch][1][RSUM_W-1]}}, r_s2[ch][1]}
                                + {{2{r_s2[ch][2][RSUM_W-1]}}, r_s2[ch][2]});
            end
        end
    end

    assign o_valid = r_v3;
    assign o_red   = r_o3[0];
    assign o_green = r_o3[1];
    assign o_blue  = r_o3[2];
    assign o_tag   = r_tag3;

endmodule

[bench/conv3x3_rgb_clamp_edge_test.sv]
module conv3x3_rgb_clamp_edge_test;
    timeunit 1ns;
    timeprecision 1ps;

    import c3c_pkg::*;

    localparam int TAPS_W        = TLO_W + THI_W;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASE  = 85;
    localparam int WIDTH_AT_RST  = 640;
    localparam int HEIGHT_AT_RST = 480;
    localparam longint CH_MAX    = (1 << CH_W) - 1;
    localparam logic [TAPS_W-1:0] IDENTITY_TAPS =
        TAPS_W'(1 << COEF_FRAC_BITS) << (4 * TAP_W);

    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        bit              hold;
    } rgb_request_t;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             done;
        logic             last;
    } filt_px_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [7:0]          i_red_in = '0;
    logic [7:0]          i_green_in = '0;
    logic [7:0]          i_blue_in = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [7:0]          o_red_out;
    logic [7:0]          o_green_out;
    logic [7:0]          o_blue_out;
    logic [9:0]          o_out_col;
    logic [11:0]         o_out_row;
    logic                o_frame_done;
    logic                o_run_last;

    rgb_request_t        request_q [$];
    filt_px_t            filtered_q [$];
    int unsigned         mismatches = 0;
    int unsigned         idle_cycles = 0;
    int                  send_gap_pct = 0;
    int                  stall_pct = 0;

    logic [WCFG_W-1:0]   cfg_width;
    logic [HCFG_W-1:0]   cfg_height;
    logic [TLO_W-1:0]    cfg_taps_lo;
    logic [THI_W-1:0]    cfg_taps_hi;
    logic [PIX_W-1:0]    prev_row [MAX_WIDTH];
    logic [PIX_W-1:0]    prev_row2 [MAX_WIDTH];
    logic [PIX_W-1:0]    window_px [9];
    logic [COL_W-1:0]    col_pos;
    logic [ROW_W-1:0]    row_pos;

    conv3x3_rgb_clamp_edge DUT (
        .i_clk, .i_rst_n,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_valid, .o_ready, .i_red_in, .i_green_in, .i_blue_in,
        .o_valid, .i_ready, .o_red_out, .o_green_out, .o_blue_out,
        .o_out_col, .o_out_row, .o_frame_done, .o_run_last
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int tap_value(int i);
        logic [TAP_W-1:0] raw;
        if (i < 5) begin
            raw = cfg_taps_lo[TAP_W*i +: TAP_W];
        end else begin
            raw = cfg_taps_hi[TAP_W*(i-5) +: TAP_W];
        end
        return $signed(raw);
    endfunction

    function automatic logic [CH_W-1:0] floor_clamp(longint acc);
        longint q;
        q = acc >>> COEF_FRAC_BITS;
        if (q < 0) return '0;
        if (q > CH_MAX) return CH_MAX[CH_W-1:0];
        return q[CH_W-1:0];
    endfunction

    function automatic void emit_filtered(bit bottom, bit right_end, int x, int y, bit done);
        longint           acc [3];
        int               rs;
        int               cs;
        int               k;
        logic [PIX_W-1:0] p;
        filt_px_t         f;
        for (int ch = 0; ch < 3; ch++) acc[ch] = 0;
        for (int ky = 0; ky < 3; ky++) begin
            for (int kx = 0; kx < 3; kx++) begin
                rs = bottom ? ((ky == 0) ? 1 : 2) : ky;
                cs = right_end ? ((kx == 0) ? 1 : 2) : kx;
                p = window_px[rs*3 + cs];
                k = tap_value(ky*3 + kx);
                for (int ch = 0; ch < 3; ch++)
                    acc[ch] += longint'(p[PIX_W-1-CH_W*ch -: CH_W]) * k;
            end
        end
        f.red   = floor_clamp(acc[0]);
        f.green = floor_clamp(acc[1]);
        f.blue  = floor_clamp(acc[2]);
        f.col   = x[COL_W-1:0];
        f.row   = y[ROW_W-1:0];
        f.done  = done;
        f.last  = 1'b0;
        filtered_q.insert(filtered_q.size(), f);
    endfunction

    function automatic void convolve_pixel(logic [PIX_W-1:0] pix);
        int               w;
        int               h;
        int               c;
        int               r;
        int               n0;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] v;
        bit               lc;
        bit               lr;
        filt_px_t         f;
        w = cfg_width;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = cfg_height;
        if (h < 2) h = 2;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        c = col_pos;
        r = row_pos;

        mid = prev_row[c];
        top = (r <= 1) ? mid : prev_row2[c];
        prev_row2[c] = mid;
        prev_row[c] = pix;
        for (int k = 0; k < 3; k++) begin
            v = (k == 0) ? top : (k == 1) ? mid : pix;
            if (c == 0) begin
                window_px[k*3]   = v;
                window_px[k*3+1] = v;
            end else begin
                window_px[k*3]   = window_px[k*3+1];
                window_px[k*3+1] = window_px[k*3+2];
            end
            window_px[k*3+2] = v;
        end

        lc = (c >= w - 1);
        lr = (r >= h - 1);
        n0 = filtered_q.size();
        if (r >= 1) begin
            if (c >= 1) emit_filtered(1'b0, 1'b0, c - 1, r - 1, 1'b0);
            if (lc) emit_filtered(1'b0, 1'b1, c, r - 1, 1'b0);
            if (lr) begin
                if (c >= 1) emit_filtered(1'b1, 1'b0, c - 1, r, 1'b0);
                if (lc) emit_filtered(1'b1, 1'b1, c, r, 1'b1);
            end
        end
        if (filtered_q.size() > n0) begin
            f = filtered_q.pop_back();
            f.last = 1'b1;
            filtered_q.insert(filtered_q.size(), f);
        end

        if (lc) begin
            col_pos = '0;
            row_pos = lr ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    // predictor state, register shadow and result checking
    always @(posedge i_clk) begin
        filt_px_t want;
        filt_px_t got;
        if (!i_rst_n) begin
            cfg_width   = WCFG_W'(WIDTH_AT_RST);
            cfg_height  = HCFG_W'(HEIGHT_AT_RST);
            cfg_taps_lo = TLO_W'(1 << COEF_FRAC_BITS);
            cfg_taps_hi = '0;
            foreach (prev_row[i]) begin
                prev_row[i]  = '0;
                prev_row2[i] = '0;
            end
            foreach (window_px[i]) window_px[i] = '0;
            col_pos = '0;
            row_pos = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:3])
                    REG_WIDTH:   cfg_width   = pwdata[WCFG_W-1:0];
                    REG_HEIGHT:  cfg_height  = pwdata[HCFG_W-1:0];
                    REG_TAPS_LO: cfg_taps_lo = pwdata[TLO_W-1:0];
                    REG_TAPS_HI: cfg_taps_hi = pwdata[THI_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) convolve_pixel({i_red_in, i_green_in, i_blue_in});
            if (o_valid && i_ready) begin
                got = '{o_red_out, o_green_out, o_blue_out, o_out_col, o_out_row,
                        o_frame_done, o_run_last};
                if (filtered_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: rgb %02h %02h %02h col %0d row %0d",
                                 got.red, got.green, got.blue, got.col, got.row);
                end else begin
                    want = filtered_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch: expected rgb %02h %02h %02h col %0d row %0d %b%b",
                                     want.red, want.green, want.blue, want.col, want.row,
                                     want.done, want.last);
                            $display("          actual   rgb %02h %02h %02h col %0d row %0d %b%b",
                                     got.red, got.green, got.blue, got.col, got.row,
                                     got.done, got.last);
                        end
                    end
                end
            end
        end
    end

    // pixel request driver
    always @(posedge i_clk) begin
        rgb_request_t req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_gap_pct
                    && !(request_q[0].hold && (i_valid || filtered_q.size() != 0))) begin
                req = request_q.pop_front();
                i_valid    <= 1'b1;
                i_red_in   <= req.red;
                i_green_in <= req.green;
                i_blue_in  <= req.blue;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold until the input side is empty and every result is back
    task automatic settle();
        do @(posedge i_clk);
        while (request_q.size() != 0 || i_valid || filtered_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] with_noise(logic [DATA_W-1:0] v, int bits);
        logic [DATA_W-1:0] n;
        n = {$urandom(), $urandom()};
        return (n << bits) | v;
    endfunction

    task automatic configure(int w, int h, logic [TAPS_W-1:0] taps);
        settle();
        write_reg(REG_WIDTH, with_noise(DATA_W'(w), WCFG_W));
        write_reg(REG_HEIGHT, with_noise(DATA_W'(h), HCFG_W));
        write_reg(REG_TAPS_LO, with_noise(taps[TLO_W-1:0], TLO_W));
        write_reg(REG_TAPS_HI, with_noise(taps[TAPS_W-1:TLO_W], THI_W));
    endtask

    function automatic logic [TAPS_W-1:0] random_taps();
        logic [TAPS_W-1:0] t;
        bit                wide;
        wide = ($urandom_range(3) == 0);
        for (int i = 0; i < 9; i++)
            t[TAP_W*i +: TAP_W] = wide ? TAP_W'($urandom())
                                       : TAP_W'($urandom_range(128)) - TAP_W'(48);
        return t;
    endfunction

    function automatic void queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit hold);
        rgb_request_t req;
        req.red   = r;
        req.green = g;
        req.blue  = b;
        req.hold  = hold;
        request_q.insert(request_q.size(), req);
    endfunction

    function automatic void queue_random(int n);
        for (int i = 0; i < n; i++)
            queue_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()),
                        $urandom_range(49) == 0);
    endfunction

    function automatic void queue_extremes();
        queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'hAA, 8'h55, 8'hFF, 1'b0);
        queue_pixel(8'h55, 8'hAA, 8'h00, 1'b0);
    endfunction

    initial begin
        int fw;
        int fh;
        int raw_w;
        int raw_h;
        int cut;
        int queued;
        bit need_cfg;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // saturated 2x2 geometry with identity, max, min and box kernels
        configure(1, 0, IDENTITY_TAPS);
        queue_extremes();
        configure(2, 2, {9{12'h7FF}});
        queue_extremes();
        configure(0, 1, {9{12'h800}});
        queue_extremes();
        configure(2, 2, {9{12'h01C}});
        queue_extremes();

        // saturated height, then end the frame early by lowering it
        configure(2, 8191, random_taps());
        queue_random(4);
        queue_pixel(8'h0F, 8'hF0, 8'h3C, 1'b1);
        queue_pixel(8'hC3, 8'h81, 8'h7E, 1'b0);
        settle();
        write_reg(REG_HEIGHT, with_noise(DATA_W'(2), HCFG_W));
        queue_random(2);

        // saturated width, then narrow the frame past the current column
        configure(2047, 3, random_taps());
        queue_random(8);
        settle();
        write_reg(REG_WIDTH, with_noise(DATA_W'(3), WCFG_W));
        queue_random(5);
        settle();
        write_reg(REG_WIDTH, with_noise(DATA_W'(2), WCFG_W));
        queue_random(1);

        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct = (ph == 1) ? 60 : (ph == 3) ? 33 : 0;
            stall_pct    = (ph == 2) ? 60 : (ph == 3) ? 33 : 0;
            queued   = 0;
            need_cfg = 1'b1;
            while (queued < RANDOM_PHASE) begin
                if (need_cfg || $urandom_range(1) == 1) begin
                    fw = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(2, 8);
                    fh = $urandom_range(2, 5);
                    raw_w = fw;
                    raw_h = fh;
                    if ($urandom_range(9) == 0) begin
                        fw = 2;
                        raw_w = $urandom_range(1);
                    end
                    if ($urandom_range(9) == 0) begin
                        fh = 2;
                        raw_h = $urandom_range(1);
                    end
                    configure(raw_w, raw_h, random_taps());
                    need_cfg = 1'b0;
                end
                if (fh > 2 && $urandom_range(5) == 0) begin
                    cut = $urandom_range(1, fh - 2);
                    queue_random(fw * cut);
                    settle();
                    write_reg(REG_HEIGHT,
                              with_noise(DATA_W'($urandom_range(2, cut + 1)), HCFG_W));
                    queue_random(fw);
                    queued += fw * (cut + 1);
                    need_cfg = 1'b1;
                end else begin
                    queue_random(fw * fh);
                    queued += fw * fh;
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
